// File: hw/rtl/bitstream_container_unwrapper_defines.svh
// assertion macros used by the top level of the container unwrapper
`ifndef BITSTREAM_CONTAINER_UNWRAPPER_DEFINES_SVH
`define BITSTREAM_CONTAINER_UNWRAPPER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked at every clock edge while reset is released
`define BCU_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every clock edge, reset included
`define BCU_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCU_ASSERT(name, clk, rst_n, prop, msg)
`define BCU_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// File: hw/rtl/bcu_pkg.sv
// types, codes and magic tables of the bitstream container unwrapper
`default_nettype none
package bcu_pkg;

  // error codes of an error report
  localparam logic [2:0] ErrFileMagic = 3'd0;
  localparam logic [2:0] ErrUnknownField = 3'd1;
  localparam logic [2:0] ErrMetaTooLong = 3'd2;
  localparam logic [2:0] ErrFwTooSmall = 3'd3;
  localparam logic [2:0] ErrUnaligned = 3'd4;
  localparam logic [2:0] ErrFwMagic = 3'd5;
  localparam logic [2:0] ErrBadSync = 3'd6;
  localparam logic [2:0] ErrTruncated = 3'd7;

  // field types
  localparam logic [7:0] TypeMetaFirst = 8'h61;
  localparam logic [7:0] TypeMetaLast = 8'h64;
  localparam logic [7:0] TypeFirmware = 8'h65;

  // sync words as seen in file byte order
  localparam logic [31:0] SyncSwapped = 32'hAA995566;
  localparam logic [31:0] SyncPlain = 32'h665599AA;

  localparam logic [15:0] MaxMetaReset = 16'd256;
  localparam logic [31:0] FwMinLength = 32'd52;
  localparam logic [31:0] FwMagicLength = 32'd48;

  // what one parsed byte leaves for the output side
  typedef struct packed {
    logic        word_v;
    logic [31:0] word;
    logic        last;
    logic        err_v;
    logic [2:0]  code;
  } event_t;

  // queue head as seen by the output side
  typedef struct packed {
    logic   valid;
    event_t ev;
  } head_t;

  // 13-byte file magic
  function automatic logic [7:0] file_magic_byte(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0, 4'd10, 4'd11: v = 8'h00;
      4'd1: v = 8'h09;
      4'd2, 4'd4, 4'd6, 4'd8: v = 8'h0f;
      4'd3, 4'd5, 4'd7, 4'd9: v = 8'hf0;
      4'd12: v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // 48-byte firmware magic
  function automatic logic [7:0] fw_magic_byte(input logic [5:0] idx);
    logic [7:0] v;
    case (idx)
      6'd32, 6'd33, 6'd34, 6'd38: v = 8'h00;
      6'd35: v = 8'hbb;
      6'd36: v = 8'h11;
      6'd37: v = 8'h22;
      6'd39: v = 8'h44;
      default: v = 8'hff;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bcu_front.sv
// byte parser: walks the container fields and classifies each beat
`default_nettype none
module bcu_front
  import bcu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_file_i,
  input  wire logic        cfg_valid_i,
  input  wire logic [15:0] cfg_data_i,
  output event_t           ev_o,
  output logic             push_o
);

  localparam logic [3:0] PhFileMagic = 4'd0;
  localparam logic [3:0] PhType = 4'd1;
  localparam logic [3:0] PhMetaLen = 4'd2;
  localparam logic [3:0] PhMetaSkip = 4'd3;
  localparam logic [3:0] PhFwLen = 4'd4;
  localparam logic [3:0] PhFwMagic = 4'd5;
  localparam logic [3:0] PhFwData = 4'd6;
  localparam logic [3:0] PhDone = 4'd7;
  localparam logic [3:0] PhError = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] acc_q, acc_d;
  logic        swap_q, swap_d;
  logic [23:0] wb_q, wb_d;
  logic [1:0]  biw_q, biw_d;
  logic        first_q, first_d;
  logic [15:0] max_meta_q;

  logic        err;
  logic [2:0]  code;
  logic [31:0] w;
  logic        swap_n;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_meta_q <= MaxMetaReset;
    end else if (cfg_valid_i) begin
      max_meta_q <= cfg_data_i;
    end
  end

  // next parse state and the event of this beat
  always_comb begin
    phase_d = phase_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    acc_d = acc_q;
    swap_d = swap_q;
    wb_d = wb_q;
    biw_d = biw_q;
    first_d = first_q;
    err = 1'b0;
    code = ErrFileMagic;
    w = {wb_q, data_byte_i};
    swap_n = swap_q;
    ev_o = '0;
    case (phase_q)
      PhFileMagic: begin
        if (data_byte_i != file_magic_byte(cnt_q[3:0])) begin
          err = 1'b1;
          code = ErrFileMagic;
        end else if (cnt_q == 6'd12) begin
          cnt_d = '0;
          phase_d = PhType;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      PhType: begin
        cnt_d = '0;
        acc_d = '0;
        if (data_byte_i >= TypeMetaFirst && data_byte_i <= TypeMetaLast) begin
          phase_d = PhMetaLen;
        end else if (data_byte_i == TypeFirmware) begin
          phase_d = PhFwLen;
        end else begin
          err = 1'b1;
          code = ErrUnknownField;
        end
      end
      PhMetaLen: begin
        acc_d = {acc_q[23:0], data_byte_i};
        if (cnt_q[0]) begin
          if (acc_d[15:0] > max_meta_q) begin
            err = 1'b1;
            code = ErrMetaTooLong;
          end else if (acc_d[15:0] == 16'd0) begin
            phase_d = PhType;
          end else begin
            rem_d = {16'd0, acc_d[15:0]};
            phase_d = PhMetaSkip;
          end
        end else begin
          cnt_d = 6'd1;
        end
      end
      PhMetaSkip: begin
        rem_d = rem_q - 32'd1;
        if (rem_q == 32'd1) begin
          phase_d = PhType;
        end
      end
      PhFwLen: begin
        acc_d = {acc_q[23:0], data_byte_i};
        if (cnt_q[1:0] == 2'd3) begin
          if (acc_d < FwMinLength) begin
            err = 1'b1;
            code = ErrFwTooSmall;
          end else if (acc_d[1:0] != 2'd0) begin
            err = 1'b1;
            code = ErrUnaligned;
          end else begin
            rem_d = acc_d - FwMagicLength;
            cnt_d = '0;
            phase_d = PhFwMagic;
          end
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      PhFwMagic: begin
        if (data_byte_i != fw_magic_byte(cnt_q)) begin
          err = 1'b1;
          code = ErrFwMagic;
        end else if (cnt_q == 6'd47) begin
          cnt_d = '0;
          biw_d = '0;
          wb_d = '0;
          first_d = 1'b1;
          phase_d = PhFwData;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      PhFwData: begin
        if (biw_q != 2'd3) begin
          wb_d = {wb_q[15:0], data_byte_i};
          biw_d = biw_q + 2'd1;
        end else begin
          biw_d = '0;
          wb_d = '0;
          // the sync word decides the byte order of every word
          if (first_q) begin
            if (w == SyncSwapped) begin
              swap_n = 1'b1;
            end else if (w == SyncPlain) begin
              swap_n = 1'b0;
            end else begin
              err = 1'b1;
              code = ErrBadSync;
            end
          end
          swap_d = swap_n;
          if (!err) begin
            first_d = 1'b0;
            rem_d = rem_q - 32'd4;
            ev_o.word_v = 1'b1;
            ev_o.word = swap_n ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
            ev_o.last = (rem_q == 32'd4);
            if (rem_q == 32'd4) begin
              phase_d = PhDone;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (err) begin
      phase_d = PhError;
      ev_o.err_v = 1'b1;
      ev_o.code = code;
    end

    // end of file: report an unfinished file, then start over
    if (end_of_file_i) begin
      if (phase_d != PhDone && phase_d != PhError) begin
        ev_o.err_v = 1'b1;
        ev_o.code = ErrTruncated;
      end
      phase_d = PhFileMagic;
      cnt_d = '0;
      rem_d = '0;
      acc_d = '0;
      swap_d = 1'b0;
      wb_d = '0;
      biw_d = '0;
      first_d = 1'b0;
    end
  end

  assign push_o = accept_i && (ev_o.word_v || ev_o.err_v);

  // parse state moves only on accepted beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFileMagic;
      cnt_q <= '0;
      rem_q <= '0;
      acc_q <= '0;
      swap_q <= 1'b0;
      wb_q <= '0;
      biw_q <= '0;
      first_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q <= cnt_d;
      rem_q <= rem_d;
      acc_q <= acc_d;
      swap_q <= swap_d;
      wb_q <= wb_d;
      biw_q <= biw_d;
      first_q <= first_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bcu_fifo.sv
// short event queue between parser and output side
`default_nettype none
module bcu_fifo
  import bcu_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire event_t ev_i,
  input  wire logic   pop_i,
  output head_t       head_o,
  output logic        full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  event_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_pop;

  assign full_o = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.ev = mem_q[rd_q];
  assign do_pop = pop_i && head_o.valid;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ev_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bcu_back.sv
// output side: splits events into result beats behind an output register
`default_nettype none
module bcu_back
  import bcu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire head_t       head_i,
  output logic             pop_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic             kind_o,
  output logic [31:0]      word_o,
  output logic [2:0]       code_o,
  output logic             last_o
);

  logic        valid_q;
  logic        kind_q, last_q;
  logic [31:0] word_q;
  logic [2:0]  code_q;
  logic        pend_q;
  logic [2:0]  pend_code_q;
  logic        load;

  // output register free or being emptied this cycle
  assign load = !valid_q || ready_i;
  assign pop_o = load && !pend_q && head_i.valid;

  assign valid_o = valid_q;
  assign kind_o = kind_q;
  assign word_o = word_q;
  assign code_o = code_q;
  assign last_o = last_q;

  // control: beat valid and the error still owed by the last event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q <= 1'b0;
      end else if (head_i.valid) begin
        valid_q <= 1'b1;
        pend_q <= head_i.ev.word_v && head_i.ev.err_v;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  // payload: a word goes first, its error report after it
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        kind_q <= 1'b1;
        word_q <= '0;
        code_q <= pend_code_q;
        last_q <= 1'b0;
      end else if (head_i.valid) begin
        pend_code_q <= head_i.ev.code;
        if (head_i.ev.word_v) begin
          kind_q <= 1'b0;
          word_q <= head_i.ev.word;
          code_q <= '0;
          last_q <= head_i.ev.last;
        end else begin
          kind_q <= 1'b1;
          word_q <= '0;
          code_q <= head_i.ev.code;
          last_q <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bitstream_container_unwrapper.sv
// top level of the bitstream container unwrapper
//
//   channel   direction  payload
//   s_axis    in         tdata[7:0] data_byte, tlast end_of_file
//   m_axis    out        tdata[31:0] word, [34:32] error_code; tuser kind; tlast last
//   cfg       in         cfg_data_i[15:0] max_meta_length
//
// one byte is accepted per clock while the event queue has room; a byte that
// ends a word and also ends the file gives two result beats, the error report
// following the word. a byte's result passes the queue write and then the
// output register. reset clears parse state, queue and output; max_meta_length
// returns to 256. an output stall backs up through the queue and only then
// holds s_axis_tready low.
`default_nettype none
`include "bitstream_container_unwrapper_defines.svh"
module bitstream_container_unwrapper
  import bcu_pkg::*;
#(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // data_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // word, error_code, zero fill
  output logic [0:0]       m_axis_tuser,  // kind
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  event_t      ev;
  logic        push;
  logic        pop;
  logic        full;
  head_t       head;
  logic        accept;
  logic        kind;
  logic [31:0] word;
  logic [2:0]  code;

  assign s_axis_tready = !full;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  bcu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (s_axis_tdata),
    .end_of_file_i (s_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .ev_o          (ev),
    .push_o        (push)
  );

  bcu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ev_i   (ev),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  bcu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .kind_o  (kind),
    .word_o  (word),
    .code_o  (code),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, code, word};
  assign m_axis_tuser = kind;

  // consistency of result beats
  `BCU_ASSERT(a_last_is_word, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser[0], "last flag on an error report")
  `BCU_ASSERT(a_err_word_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0, "error report carries a word")
  `BCU_ASSERT(a_word_code_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[34:32] == 3'd0, "firmware word carries an error code")
  `BCU_ASSERT(a_no_pop_empty, clk_i, rst_ni, pop |-> head.valid || !m_axis_tvalid || m_axis_tready, "queue popped while output held")

endmodule
`default_nettype wire

// File: tb/sv/bitstream_container_unwrapper_tb.sv
// self-checking testbench for the bitstream container unwrapper
`timescale 1ns / 100ps
module bitstream_container_unwrapper_tb;
  import bcu_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned FileHeadLength = 13;
  localparam logic KindWord = 1'b0;
  localparam logic KindError = 1'b1;
  localparam logic [2:0] CodeNone = 3'd0;

  // fixed bytes at the head of every container file
  localparam logic [7:0] FileHead [13] = '{
    8'h00, 8'h09, 8'h0f, 8'hf0, 8'h0f, 8'hf0, 8'h0f, 8'hf0, 8'h0f, 8'hf0, 8'h00, 8'h00, 8'h01
  };

  // firmware preamble ahead of the sync word
  localparam logic [7:0] FwPreamble [48] = '{
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'h00, 8'h00, 8'h00, 8'hbb, 8'h11, 8'h22, 8'h00, 8'h44,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff
  };

  typedef enum logic [3:0] {
    PhFileMagic, PhType, PhMetaLen, PhMetaSkip, PhFwLen, PhFwMagic, PhFwData, PhDone, PhError
  } parse_phase_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
    logic [2:0]  code;
    logic        last;
  } result_beat_t;

  // container parser copy plus the queue of result beats still owed by the block
  class unwrap_scoreboard;
    logic [15:0]  meta_limit;
    parse_phase_e phase;
    logic [31:0]  field_count;
    logic [31:0]  left;
    logic [31:0]  len_acc;
    logic         swap;
    logic [23:0]  partial;
    logic [1:0]   lane;
    result_beat_t owed[$];
    int unsigned  faults;

    function new();
      meta_limit = MaxMetaReset;
      faults = 0;
      restart();
    endfunction

    function void restart();
      phase = PhFileMagic;
      field_count = '0;
      left = '0;
      len_acc = '0;
      swap = 1'b0;
      partial = '0;
      lane = '0;
    endfunction

    function void set_meta_limit(logic [15:0] v);
      meta_limit = v;
    endfunction

    function void owe(logic kind, logic [31:0] word, logic [2:0] code, logic last);
      result_beat_t r;
      r.kind = kind;
      r.word = word;
      r.code = code;
      r.last = last;
      owed.push_back(r);
    endfunction

    // advance the parser by one accepted byte
    function void note_byte(logic [7:0] b, logic eof);
      logic        fail;
      logic [2:0]  code;
      logic [31:0] w;
      fail = 1'b0;
      code = ErrFileMagic;
      case (phase)
        PhFileMagic: begin
          if (b != FileHead[field_count]) begin
            fail = 1'b1;
            code = ErrFileMagic;
          end else begin
            field_count++;
            if (field_count == FileHeadLength) phase = PhType;
          end
        end
        PhType: begin
          field_count = '0;
          len_acc = '0;
          if (b >= TypeMetaFirst && b <= TypeMetaLast) phase = PhMetaLen;
          else if (b == TypeFirmware) phase = PhFwLen;
          else begin
            fail = 1'b1;
            code = ErrUnknownField;
          end
        end
        PhMetaLen: begin
          len_acc = {len_acc[23:0], b};
          field_count++;
          if (field_count >= 2) begin
            if (len_acc > meta_limit) begin
              fail = 1'b1;
              code = ErrMetaTooLong;
            end else if (len_acc == 0) begin
              phase = PhType;
            end else begin
              left = len_acc;
              phase = PhMetaSkip;
            end
          end
        end
        PhMetaSkip: begin
          left--;
          if (left == 0) phase = PhType;
        end
        PhFwLen: begin
          len_acc = {len_acc[23:0], b};
          field_count++;
          if (field_count >= 4) begin
            if (len_acc < FwMinLength) begin
              fail = 1'b1;
              code = ErrFwTooSmall;
            end else if (len_acc[1:0] != 2'd0) begin
              fail = 1'b1;
              code = ErrUnaligned;
            end else begin
              left = len_acc - FwMagicLength;
              field_count = '0;
              phase = PhFwMagic;
            end
          end
        end
        PhFwMagic: begin
          if (b != FwPreamble[field_count]) begin
            fail = 1'b1;
            code = ErrFwMagic;
          end else begin
            field_count++;
            if (field_count == FwMagicLength) begin
              field_count = '0;
              lane = '0;
              partial = '0;
              phase = PhFwData;
            end
          end
        end
        PhFwData: begin
          if (lane != 2'd3) begin
            partial = {partial[15:0], b};
            lane++;
          end else begin
            w = {partial, b};
            lane = '0;
            partial = '0;
            // first word decides the byte order of the whole image
            if (field_count == 0) begin
              if (w == SyncSwapped) swap = 1'b1;
              else if (w == SyncPlain) swap = 1'b0;
              else begin
                fail = 1'b1;
                code = ErrBadSync;
              end
            end
            if (!fail) begin
              if (swap) w = {w[7:0], w[15:8], w[23:16], w[31:24]};
              field_count++;
              left -= 4;
              if (left == 0) phase = PhDone;
              owe(KindWord, w, CodeNone, left == 0);
            end
          end
        end
        default: begin
        end
      endcase

      if (fail) begin
        phase = PhError;
        owe(KindError, '0, code, 1'b0);
      end

      // end of file: report an unfinished image, then start over
      if (eof) begin
        if (phase != PhDone && phase != PhError) owe(KindError, '0, ErrTruncated, 1'b0);
        restart();
      end
    endfunction

    // compare one accepted output beat with the oldest owed one
    function void check_beat(result_beat_t got);
      result_beat_t want;
      if (owed.size() == 0) begin
        $error("unexpected beat: kind %0d word %h error_code %0d last %0d",
               got.kind, got.word, got.code, got.last);
        faults++;
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        faults++;
      end
      if (got.word !== want.word) begin
        $error("word: expected %h, got %h", want.word, got.word);
        faults++;
      end
      if (got.code !== want.code) begin
        $error("error_code: expected %0d, got %0d", want.code, got.code);
        faults++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        faults++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // data_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // word [31:0], error_code [34:32], zero fill
  logic [0:0]  m_axis_tuser;        // kind
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  unwrap_scoreboard sb;
  logic [7:0]       file_img[$];
  logic [15:0]      meta_limit = MaxMetaReset;
  logic             in_calm = 1'b0;
  logic             out_calm = 1'b0;
  int unsigned      bytes_sent = 0;
  int unsigned      beats_seen = 0;
  int unsigned      cycle_count = 0;

  bitstream_container_unwrapper i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[bitstream_container_unwrapper] ERROR");
      $finish;
    end
  end

  // result beats are checked at the edge that accepts them
  always @(posedge clk_i) begin : watch_results
    result_beat_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser[0];
      got.word = m_axis_tdata[31:0];
      got.code = m_axis_tdata[34:32];
      got.last = m_axis_tlast;
      sb.check_beat(got);
      beats_seen++;
    end
  end

  // output side: a random stall drawn per beat, landing on the beat itself
  initial begin : out_side
    int unsigned hold;
    forever begin
      hold = out_calm ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        do @(posedge clk_i); while (!m_axis_tvalid);
        repeat (hold - 1) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // image building
  function automatic void put_magic();
    foreach (FileHead[i]) file_img.push_back(FileHead[i]);
  endfunction

  function automatic void put_meta(logic [7:0] tag, int unsigned len, int unsigned body);
    logic [15:0] l;
    l = len[15:0];
    file_img.push_back(tag);
    file_img.push_back(l[15:8]);
    file_img.push_back(l[7:0]);
    repeat (body) file_img.push_back(8'($urandom));
  endfunction

  function automatic void put_fw_len(logic [31:0] len);
    file_img.push_back(TypeFirmware);
    for (int k = 3; k >= 0; k--) file_img.push_back(len[8*k +: 8]);
  endfunction

  function automatic void put_fw(int unsigned nwords, logic swapped);
    logic [31:0] w;
    foreach (FwPreamble[i]) file_img.push_back(FwPreamble[i]);
    for (int unsigned i = 0; i < nwords; i++) begin
      if (i == 0) w = swapped ? SyncSwapped : SyncPlain;
      else begin
        case ($urandom_range(0, 3))
          0: w = '0;
          1: w = '1;
          default: w = $urandom;
        endcase
      end
      for (int k = 3; k >= 0; k--) file_img.push_back(w[8*k +: 8]);
    end
  endfunction

  // metadata length: mostly short, sometimes at or just over the limit or random
  function automatic int unsigned pick_meta_len();
    case ($urandom_range(0, 15))
      0: return meta_limit;
      1: return (meta_limit == 16'hFFFF) ? 32'hFFFF : meta_limit + 1;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(0, 24);
    endcase
  endfunction

  // random image: mostly well formed, the rest noise or damaged
  function automatic void build_random_image();
    int unsigned mode;
    int unsigned nwords;
    int unsigned len;
    int unsigned body;
    int unsigned body_at;
    logic [31:0] fw_len;
    file_img.delete();
    mode = $urandom_range(0, 15);
    if (mode == 0) begin
      repeat ($urandom_range(1, 24)) file_img.push_back(8'($urandom));
      return;
    end
    put_magic();
    repeat ($urandom_range(0, 3)) begin
      len = pick_meta_len();
      if (len > meta_limit) body = $urandom_range(0, 4);
      else body = (len > 300) ? 300 : len;
      put_meta(8'($urandom_range(TypeMetaFirst, TypeMetaLast)), len, body);
    end
    nwords = $urandom_range(1, 6);
    fw_len = 48 + 4 * nwords;
    if (mode == 1) begin
      case ($urandom_range(0, 3))
        0: fw_len = $urandom_range(0, 51);
        1: fw_len = 52 + 4 * $urandom_range(0, 20) + $urandom_range(1, 3);
        2: fw_len = $urandom;
        default: fw_len = 48 + 4 * (nwords + $urandom_range(1, 4));
      endcase
    end
    put_fw_len(fw_len);
    body_at = file_img.size();
    put_fw(nwords, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 2)) file_img.push_back(8'($urandom));
    case (mode)
      2, 3: file_img[$urandom_range(0, file_img.size() - 1)] = 8'($urandom);
      4: file_img = file_img[0:$urandom_range(0, file_img.size() - 1)];
      5: file_img[body_at + 48 + $urandom_range(0, 3)] = 8'($urandom);
      6: file_img[body_at + $urandom_range(0, 47)] ^= 8'(1 << $urandom_range(0, 7));
      default: begin
      end
    endcase
  endfunction

  // one byte on s_axis after a drawn gap
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, eof);
    bytes_sent++;
  endtask

  // whole image, end of file on its last byte
  task automatic send_image();
    foreach (file_img[i]) send_byte(file_img[i], i == file_img.size() - 1);
  endtask

  // register write once every owed beat is out and the pipeline has drained
  task automatic write_meta_limit(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_meta_limit(v);
    meta_limit = v;
  endtask

  initial begin : stimulus
    logic [15:0] limits [5];
    int unsigned phase_start;
    sb = new();
    limits[0] = 16'd0;
    limits[1] = 16'hFFFF;
    limits[2] = 16'd1;
    limits[3] = 16'($urandom);
    limits[4] = MaxMetaReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain image with empty and full-size metadata, bytes after the firmware
    file_img.delete();
    put_magic();
    put_meta(TypeMetaFirst, 0, 0);
    put_meta(TypeMetaLast, 256, 256);
    put_meta(8'h63, 5, 5);
    put_fw_len(48 + 16);
    put_fw(4, 1'b0);
    file_img.push_back(8'hFF);
    file_img.push_back(8'h00);
    send_image();

    // swapped image, end of file on the last firmware byte
    file_img.delete();
    put_magic();
    put_fw_len(56);
    put_fw(2, 1'b1);
    send_image();

    // bad file magic in its final byte
    file_img.delete();
    put_magic();
    file_img[12] = 8'h02;
    file_img.push_back(TypeFirmware);
    send_image();

    // unknown field type
    file_img.delete();
    put_magic();
    file_img.push_back(8'h60);
    file_img.push_back(8'hFF);
    send_image();

    // metadata one over the limit
    file_img.delete();
    put_magic();
    put_meta(8'h62, 257, 2);
    send_image();

    // firmware too small, then unaligned, then all-ones length
    file_img.delete();
    put_magic();
    put_fw_len(51);
    file_img.push_back(8'h00);
    send_image();
    file_img.delete();
    put_magic();
    put_fw_len(53);
    send_image();
    file_img.delete();
    put_magic();
    put_fw_len(32'hFFFFFFFF);
    send_image();

    // damaged firmware preamble
    file_img.delete();
    put_magic();
    put_fw_len(52);
    put_fw(1, 1'b0);
    file_img[18 + 35] = 8'hBA;
    send_image();

    // bad sync word
    file_img.delete();
    put_magic();
    put_fw_len(60);
    put_fw(3, 1'b0);
    file_img[18 + 48] = 8'h12;
    send_image();

    // end of file on a byte that completes a word mid-image
    file_img.delete();
    put_magic();
    put_fw_len(60);
    put_fw(3, 1'b1);
    file_img = file_img[0:18 + 48 + 7];
    send_image();

    // one-byte files: truncated magic, and wrong magic
    file_img.delete();
    file_img.push_back(8'h00);
    send_image();
    file_img.delete();
    file_img.push_back(8'hAA);
    send_image();

    // random images under each limit setting
    foreach (limits[p]) begin
      write_meta_limit(limits[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 60 || (p == 4 && beats_seen < 48)) begin
        in_calm = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
        build_random_image();
        send_image();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (2 * DrainCycles) @(posedge clk_i);
    if (sb.faults == 0 && sb.owed.size() == 0) begin
      $display("[bitstream_container_unwrapper] OK");
    end else begin
      $display("[bitstream_container_unwrapper] ERROR");
    end
    $finish;
  end

endmodule
